[src/msd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg
// shared types and constants of the morse stream decoder
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam logic [7:0] SYM_DOT   = 8'h2E;
  localparam logic [7:0] SYM_DASH  = 8'h2D;
  localparam logic [7:0] SYM_SPACE = 8'h20;
  localparam logic [7:0] SYM_END   = 8'h00;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [7:0] PATH_ROOT = 8'd1;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_LITERAL = 2'd2
  } cmd_kind_t;

  // one request from the front part to the back part
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] idx;
    logic [7:0] data;
    logic       has;
    logic       eol;
  } cmd_t;

endpackage

[src/msd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_front
// accepts text and load requests, tracks the code group, issues commands
// ----------------------------------------------------------------------------
module msd_front #(
  parameter int MAX_SYMBOLS = 7
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  logic           op,
  input  logic [7:0]     sym,
  input  logic [7:0]     tbl_idx,
  input  logic [7:0]     tbl_letter,
  output logic           push,
  output msd_pkg::cmd_t  cmd
);

  localparam logic [3:0] MaxLen = 4'(MAX_SYMBOLS);

  logic [7:0] path_r, path_nxt;
  logic [3:0] len_r, len_nxt;
  logic       ovf_r, ovf_nxt;
  logic       sp_r, sp_nxt;
  logic       grp;
  logic       push_c;

  assign grp = (len_r != 4'd0) || ovf_r;

  always_comb begin
    path_nxt = path_r;
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    sp_nxt   = sp_r;
    push_c   = 1'b0;
    cmd.kind = msd_pkg::CMD_LITERAL;
    cmd.idx  = path_r;
    cmd.data = 8'd0;
    cmd.has  = 1'b1;
    cmd.eol  = 1'b0;
    if (op == msd_pkg::OP_LOAD) begin
      push_c   = 1'b1;
      cmd.kind = msd_pkg::CMD_WRITE;
      cmd.idx  = tbl_idx;
      cmd.data = tbl_letter;
    end else if (sym == msd_pkg::SYM_DOT || sym == msd_pkg::SYM_DASH) begin
      sp_nxt = 1'b0;
      if (len_r >= MaxLen) begin
        ovf_nxt = 1'b1;
      end else begin
        path_nxt = {path_r[6:0], sym == msd_pkg::SYM_DASH};
        len_nxt  = len_r + 4'd1;
      end
    end else if (sym == msd_pkg::SYM_END) begin
      push_c  = 1'b1;
      cmd.eol = 1'b1;
      if (!grp) begin
        cmd.has = 1'b0;
      end else if (!ovf_r) begin
        cmd.kind = msd_pkg::CMD_LOOKUP;
      end
      path_nxt = msd_pkg::PATH_ROOT;
      len_nxt  = 4'd0;
      ovf_nxt  = 1'b0;
      sp_nxt   = 1'b0;
    end else if (sym == msd_pkg::SYM_SPACE) begin
      if (grp) begin
        push_c = 1'b1;
        if (!ovf_r) begin
          cmd.kind = msd_pkg::CMD_LOOKUP;
        end
        path_nxt = msd_pkg::PATH_ROOT;
        len_nxt  = 4'd0;
        ovf_nxt  = 1'b0;
        sp_nxt   = 1'b1;
      end else if (sp_r) begin
        push_c   = 1'b1;
        cmd.data = msd_pkg::SYM_SPACE;
        sp_nxt   = 1'b0;
      end
    end else begin
      sp_nxt = 1'b0;
    end
  end

  assign push = acc && push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_r <= msd_pkg::PATH_ROOT;
      len_r  <= 4'd0;
      ovf_r  <= 1'b0;
      sp_r   <= 1'b0;
    end else if (acc) begin
      path_r <= path_nxt;
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      sp_r   <= sp_nxt;
    end
  end

endmodule

[src/msd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_fifo
// short command queue between front and back parts
// ----------------------------------------------------------------------------
module msd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  msd_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           q_valid,
  output msd_pkg::cmd_t  q_cmd
);

  msd_pkg::cmd_t              q_mem_r [msd_pkg::QDEPTH];
  logic [msd_pkg::QAW-1:0]    wr_ptr_r;
  logic [msd_pkg::QAW-1:0]    rd_ptr_r;
  logic [msd_pkg::QAW:0]      cnt_r;

  assign full    = cnt_r == (msd_pkg::QAW+1)'(msd_pkg::QDEPTH);
  assign q_valid = cnt_r != '0;
  assign q_cmd   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[src/msd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_back
// code table, table reads and writes, registered result stage
// ----------------------------------------------------------------------------
module msd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  msd_pkg::cmd_t  q_cmd,
  output logic           pop,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [7:0]     out_char,
  output logic           out_has,
  output logic           out_eol
);

  logic [7:0] tbl_mem_r [256];
  logic [255:0] tbl_vld_r;
  logic [7:0] rd_data_r;
  logic       rd_vld_r;
  logic       out_valid_r, out_valid_nxt;
  logic       use_mem_r;
  logic [7:0] lit_r;
  logic       has_r;
  logic       eol_r;
  logic       is_wr;

  assign pop   = q_valid && (!out_valid_r || out_ready);
  assign is_wr = q_cmd.kind == msd_pkg::CMD_WRITE;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop && !is_wr) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_wr) begin
      tbl_mem_r[q_cmd.idx] <= q_cmd.data;
    end
    if (pop) begin
      rd_data_r <= tbl_mem_r[q_cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && is_wr) begin
        tbl_vld_r[q_cmd.idx] <= 1'b1;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !is_wr) begin
      rd_vld_r  <= tbl_vld_r[q_cmd.idx];
      use_mem_r <= q_cmd.kind == msd_pkg::CMD_LOOKUP;
      lit_r     <= q_cmd.data;
      has_r     <= q_cmd.has;
      eol_r     <= q_cmd.eol;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = use_mem_r ? (rd_vld_r ? rd_data_r : 8'd0) : lit_r;
  assign out_has   = has_r;
  assign out_eol   = eol_r;

endmodule

[src/morse_stream_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_stream_decoder_unit
// morse text decoder with a loadable code table
// ----------------------------------------------------------------------------
// Takes one request per clock unless the queue is full: a text byte to
// decode or a code table load. Dots and dashes walk a heap path from the
// root, a space or line end closes the group and yields its letter, a
// second space yields a word space, and the line end always yields a
// result marked with tlast. The front part handles the group state in the
// accepting cycle; a four-entry queue feeds the back part, which does one
// single-port table access per request, so the sustained rate is one
// request per cycle when the output is not stalled; results pass the queue
// and result registers. The table reads as zero after reset until loaded.
module morse_stream_decoder_unit #(
  parameter int MAX_SYMBOLS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // symbol, table_index, table_letter
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // character
  output logic        out_tuser,  // has_character
  output logic        out_tlast   // end_of_line
);

  logic          acc;
  logic          push;
  logic          pop;
  logic          full;
  logic          q_valid;
  msd_pkg::cmd_t push_cmd;
  msd_pkg::cmd_t q_cmd;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  msd_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .op        (in_tuser),
    .sym       (in_tdata[7:0]),
    .tbl_idx   (in_tdata[15:8]),
    .tbl_letter(in_tdata[23:16]),
    .push      (push),
    .cmd       (push_cmd)
  );

  msd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .full    (full),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  msd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .out_ready(out_tready),
    .out_valid(out_tvalid),
    .out_char (out_tdata),
    .out_has  (out_tuser),
    .out_eol  (out_tlast)
  );

  // a result without a character only comes from a line end
  a_nochar_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && out_tdata == 8'd0))
    else $error("result without character is not an empty line end");

  // queue is never popped empty
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("command queue popped while empty");

  // queue never overflows
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command queue pushed while full");

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

[test/msd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_checker
// result predictor and scoreboard for morse_stream_decoder_unit
// ----------------------------------------------------------------------------
// Watches both stream channels. Each accepted request updates a private copy
// of the code table and the group state and queues the letter it should
// produce. Each accepted result is compared field by field with the oldest
// queued letter. Mismatches and unexpected results are counted, and the
// number of letters still owed is handed to the testbench top.
module msd_checker #(
  parameter int MAX_SYMBOLS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // symbol, table_index, table_letter
  input  logic        in_tuser,   // operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // character
  input  logic        out_tuser,  // has_character
  input  logic        out_tlast,  // end_of_line
  output int          err_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0] ch;
    logic       has_ch;
    logic       eol;
  } letter_t;

  letter_t    expected_letters[$];
  logic [7:0] code_tbl [256];
  logic [7:0] path_idx;
  logic [3:0] group_len;
  logic       group_ovf;
  logic       space_pend;

  task automatic clear_group();
    path_idx  = msd_pkg::PATH_ROOT;
    group_len = 4'd0;
    group_ovf = 1'b0;
  endtask

  task automatic reset_model();
    for (int i = 0; i < 256; i++) code_tbl[i] = 8'h00;
    clear_group();
    space_pend = 1'b0;
    expected_letters.delete();
  endtask

  function automatic logic [7:0] closed_letter();
    return group_ovf ? 8'h00 : code_tbl[path_idx];
  endfunction

  task automatic decode_request(input logic op, input logic [7:0] sym,
                                input logic [7:0] idx, input logic [7:0] let_in);
    logic open_group;
    open_group = (group_len != 4'd0) || group_ovf;
    if (op == msd_pkg::OP_LOAD) begin
      code_tbl[idx] = let_in;
    end else begin
      case (sym)
        msd_pkg::SYM_DOT, msd_pkg::SYM_DASH: begin
          space_pend = 1'b0;
          if (group_len >= MAX_SYMBOLS) begin
            group_ovf = 1'b1;
          end else begin
            path_idx  = {path_idx[6:0], sym == msd_pkg::SYM_DASH};
            group_len = group_len + 4'd1;
          end
        end
        msd_pkg::SYM_END: begin
          if (open_group) expected_letters.push_back('{closed_letter(), 1'b1, 1'b1});
          else expected_letters.push_back('{8'h00, 1'b0, 1'b1});
          clear_group();
          space_pend = 1'b0;
        end
        msd_pkg::SYM_SPACE: begin
          if (open_group) begin
            expected_letters.push_back('{closed_letter(), 1'b1, 1'b0});
            clear_group();
            space_pend = 1'b1;
          end else if (space_pend) begin
            space_pend = 1'b0;
            expected_letters.push_back('{msd_pkg::SYM_SPACE, 1'b1, 1'b0});
          end
        end
        default: space_pend = 1'b0;
      endcase
    end
  endtask

  task automatic flag_error(input string what);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $time, what);
  endtask

  task automatic check_letter();
    letter_t want;
    if (expected_letters.size() == 0) begin
      flag_error($sformatf("unexpected result: char %h has %b last %b",
                           out_tdata, out_tuser, out_tlast));
    end else begin
      want = expected_letters.pop_front();
      if (out_tdata !== want.ch || out_tuser !== want.has_ch || out_tlast !== want.eol)
        flag_error($sformatf("expected char %h has %b last %b, got char %h has %b last %b",
                             want.ch, want.has_ch, want.eol,
                             out_tdata, out_tuser, out_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      err_count = 0;
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready)
        decode_request(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
      if (out_tvalid && out_tready) check_letter();
      pending <= expected_letters.size();
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for morse_stream_decoder_unit
// ----------------------------------------------------------------------------
// Runs a short directed sequence (empty line end, lone space, table loads,
// word space, ignored byte, overlong group, unknown code) and then random
// morse text mixed with table loads and stray bytes, in four phases of
// sender gaps and receiver stalls. Checking is done by msd_checker.
module tb_top;

  localparam int MAX_SYM     = 7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_REQS  = 330;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // symbol, table_index, table_letter
  logic        in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // character
  logic        out_tuser;  // has_character
  logic        out_tlast;  // end_of_line

  int err_count;
  int pending;
  int send_idle;
  int recv_stall;
  int req_count;
  int cycle_cnt;

  morse_stream_decoder_unit #(.MAX_SYMBOLS(MAX_SYM)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  msd_checker #(.MAX_SYMBOLS(MAX_SYM)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .err_count  (err_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt == CYCLE_LIMIT) begin
        $display("morse_stream_decoder_unit verification failed");
        $finish;
      end
    end
  end

  // receiver side: random stalls
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // one request, with random sender gaps before it
  task automatic push_req(input logic op, input logic [7:0] sym,
                          input logic [7:0] idx, input logic [7:0] let_in);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {let_in, idx, sym};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == msd_pkg::OP_LOAD || sym == msd_pkg::SYM_DOT || sym == msd_pkg::SYM_DASH ||
        sym == msd_pkg::SYM_SPACE || sym == msd_pkg::SYM_END)
      req_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_req(msd_pkg::OP_DECODE, s[i], 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic send_line_end();
    push_req(msd_pkg::OP_DECODE, msd_pkg::SYM_END, 8'($urandom_range(255)),
             8'($urandom_range(255)));
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [7:0] let_in);
    push_req(msd_pkg::OP_LOAD, 8'($urandom_range(255)), idx, let_in);
  endtask

  // random morse text with loads and stray bytes mixed in
  task automatic random_phase(input int goal);
    int pick;
    int n;
    int stop_at;
    stop_at = req_count + goal;
    while (req_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        load_entry(8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (pick < 13) begin
        push_req(msd_pkg::OP_DECODE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
      end else begin
        if ($urandom_range(19) == 0) n = $urandom_range(MAX_SYM + 3, MAX_SYM + 1);
        else n = $urandom_range(MAX_SYM, 1);
        for (int i = 0; i < n; i++)
          send_text($urandom_range(1) ? "-" : ".");
        pick = $urandom_range(99);
        if (pick < 55) send_text(" ");
        else if (pick < 75) send_text("  ");
        else if (pick < 90) send_line_end();
        else begin
          send_text(" ");
          push_req(msd_pkg::OP_DECODE, 8'h7E, 8'($urandom_range(255)),
                   8'($urandom_range(255)));
          send_text(" ");
        end
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 24'h0;
    in_tuser   <= msd_pkg::OP_DECODE;
    send_idle  = 0;
    recv_stall = 0;
    req_count  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    send_line_end();
    send_text(" ");
    load_entry(8'd2, "E");
    load_entry(8'd3, "T");
    load_entry(8'd5, "A");
    load_entry(8'd0, 8'hAA);
    send_text(".-  -");
    send_line_end();
    send_text(". ");
    push_req(msd_pkg::OP_DECODE, 8'hFF, 8'h00, 8'hFF);
    send_text(" ");
    send_text("--------");
    send_line_end();
    send_text("-- ");

    // random part, one phase per idle setting
    random_phase(PHASE_REQS);
    send_idle = 53;
    recv_stall = 0;
    random_phase(PHASE_REQS);
    send_idle = 0;
    recv_stall = 53;
    random_phase(PHASE_REQS);
    send_idle = 36;
    recv_stall = 36;
    random_phase(PHASE_REQS);
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("morse_stream_decoder_unit verification clean");
    end else begin
      $display("morse_stream_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
